// ===== rtl/spo2r_pkg.sv =====
// Shared types, widths and constants for the SpO2 ratio-of-ratios block.
package spo2r_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int WINDOW_MAX = 1024;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 2);
	localparam int SUM_W      = SAMPLE_W + $clog2(WINDOW_MAX);
	localparam int PP_W       = SAMPLE_W;
	localparam int NUM_W      = PP_W + SUM_W;
	localparam int CAL_W      = 8;
	localparam int FRAC_W     = 8;
	localparam int PROD_W     = CAL_W + NUM_W;
	localparam int DVD_W      = PROD_W + FRAC_W;
	localparam int Q_W        = CAL_W + FRAC_W;
	localparam int STEP_W     = $clog2(DVD_W + 1);
	localparam int SAT_W      = 15;
	localparam int CFG_IDX_W  = 8;

	localparam logic [SAT_W-1:0]     FULL_SCALE    = SAT_W'(25600);
	localparam logic [CAL_W-1:0]     INTERCEPT_RST = CAL_W'(110);
	localparam logic [CAL_W-1:0]     SLOPE_RST     = CAL_W'(25);
	localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = CFG_IDX_W'(1);

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_DEN = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL1,
		S_MUL2,
		S_DIV,
		S_FIN
	} state_t;

	// lane control: take a sample / return to reset values
	typedef struct packed {
		logic acc;
		logic clr;
	} lane_ctl_t;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [PP_W-1:0]  pp;
	} lane_res_t;

endpackage

// ===== rtl/spo2r_lane.sv =====
// One channel lane: running sum, minimum and maximum over the window.
module spo2r_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  spo2r_pkg::lane_ctl_t           ctl,
	input  logic [spo2r_pkg::SAMPLE_W-1:0] sample,
	output spo2r_pkg::lane_res_t           res
);

	logic [spo2r_pkg::SUM_W-1:0]    sum_q;
	logic [spo2r_pkg::SAMPLE_W-1:0] max_q;
	logic [spo2r_pkg::SAMPLE_W-1:0] min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			max_q <= '0;
			min_q <= '1;
		end else if (ctl.clr) begin
			sum_q <= '0;
			max_q <= '0;
			min_q <= '1;
		end else if (ctl.acc) begin
			sum_q <= sum_q + spo2r_pkg::SUM_W'(sample);
			if (sample > max_q) max_q <= sample;
			if (sample < min_q) min_q <= sample;
		end
	end

	assign res.sum = sum_q;
	assign res.pp  = max_q - min_q;

endmodule

// ===== rtl/spo2r_div.sv =====
// Restoring divider, one quotient bit per cycle, overflow-flagged quotient.
module spo2r_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spo2r_pkg::DVD_W-1:0]   dividend,
	input  logic [spo2r_pkg::NUM_W-1:0]   divisor,
	output logic                          busy,
	output logic [spo2r_pkg::Q_W-1:0]     quotient,
	output logic                          q_ovf,
	output logic                          inexact
);

	logic [spo2r_pkg::DVD_W-1:0]  dvd_q;
	logic [spo2r_pkg::NUM_W-1:0]  dsr_q;
	logic [spo2r_pkg::NUM_W-1:0]  rem_q;
	logic [spo2r_pkg::Q_W-1:0]    q_q;
	logic                         ovf_q;
	logic                         run_q;
	logic [spo2r_pkg::STEP_W-1:0] cnt_q;

	logic [spo2r_pkg::NUM_W:0]    trial;
	logic [spo2r_pkg::NUM_W:0]    diff;
	logic                         ge;

	assign trial = {rem_q, dvd_q[spo2r_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dsr_q};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= spo2r_pkg::STEP_W'(spo2r_pkg::DVD_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == spo2r_pkg::STEP_W'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[spo2r_pkg::DVD_W-2:0], 1'b0};
			rem_q <= ge ? diff[spo2r_pkg::NUM_W-1:0] : trial[spo2r_pkg::NUM_W-1:0];
			// only quotients below 2^Q_W matter, anything above sets the overflow flag
			ovf_q <= ovf_q | q_q[spo2r_pkg::Q_W-1];
			q_q   <= {q_q[spo2r_pkg::Q_W-2:0], ge};
		end
	end

	assign busy     = run_q;
	assign quotient = q_q;
	assign q_ovf    = ovf_q;
	assign inexact  = rem_q != '0;

endmodule

// ===== rtl/spo2_ratio_of_ratios_top.sv =====
// Top level of the SpO2 ratio-of-ratios estimator.
// A last item's result goes through S_MUL1, S_MUL2, the divider and S_FIN into the output register
//   (58-step bit-serial divide, one quotient bit a cycle); error results skip the divider.
// Throughput: one sample pair per cycle inside a window; after a last item the input
//   stalls until the result is loaded, which waits while the output register is full and stalled.
// Reset (arst_n low, asynchronous): window cleared, intercept 110, slope 25, no result.
module spo2_ratio_of_ratios_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [spo2r_pkg::SAMPLE_W-1:0]    ir_sample,
	input  logic [spo2r_pkg::SAMPLE_W-1:0]    red_sample,
	input  logic                              last_sample,
	// result channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [spo2r_pkg::SAT_W-1:0]       saturation_value,
	output logic [1:0]                        status,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spo2r_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spo2r_pkg::CAL_W-1:0]       cfg_data
);

	spo2r_pkg::state_t  state_q, state_d;

	logic [spo2r_pkg::CAL_W-1:0]  intercept_q;
	logic [spo2r_pkg::CAL_W-1:0]  slope_q;
	logic [spo2r_pkg::CNT_W-1:0]  count_q;

	logic                         in_acc;
	logic                         out_acc;
	logic                         win_open;
	spo2r_pkg::lane_ctl_t         lane_ctl;
	spo2r_pkg::lane_res_t         ir_res;
	spo2r_pkg::lane_res_t         red_res;

	// merge stage registers
	logic [spo2r_pkg::NUM_W-1:0]  num_s1;
	logic [spo2r_pkg::NUM_W-1:0]  den_s1;
	logic                         too_long_s1;
	spo2r_pkg::status_t           err_q;

	logic                         div_start;
	logic [spo2r_pkg::DVD_W-1:0]  div_dividend;
	logic                         div_busy;
	logic [spo2r_pkg::Q_W-1:0]    div_q;
	logic                         div_ovf;
	logic                         div_inexact;

	logic                         load_out;
	logic [spo2r_pkg::Q_W:0]      q_ceil;
	logic [spo2r_pkg::Q_W-1:0]    base;
	logic [spo2r_pkg::Q_W-1:0]    diff_v;
	logic [spo2r_pkg::SAT_W-1:0]  sat_calc;

	logic                         out_valid_q;
	logic [spo2r_pkg::SAT_W-1:0]  sat_q;
	spo2r_pkg::status_t           status_q;

	// ------------------------------------------------------------------
	// Configuration: always ready, writes beyond the list are dropped
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intercept_q <= spo2r_pkg::INTERCEPT_RST;
			slope_q     <= spo2r_pkg::SLOPE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spo2r_pkg::REG_INTERCEPT: intercept_q <= cfg_data;
				spo2r_pkg::REG_SLOPE:     slope_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sample acceptance and the two channel lanes
	// ------------------------------------------------------------------
	assign in_stall = state_q != spo2r_pkg::S_IDLE;
	assign in_acc   = in_valid && !in_stall;

	// samples past the window limit are counted but not accumulated
	assign win_open     = count_q < spo2r_pkg::CNT_W'(spo2r_pkg::WINDOW_MAX);
	assign lane_ctl.acc = in_acc && win_open;
	assign lane_ctl.clr = state_q == spo2r_pkg::S_MUL1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (lane_ctl.clr) begin
			count_q <= '0;
		end else if (in_acc && count_q <= spo2r_pkg::CNT_W'(spo2r_pkg::WINDOW_MAX)) begin
			count_q <= count_q + 1'b1;
		end
	end

	spo2r_lane u_ir_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (ir_sample),
		.res    (ir_res)
	);

	spo2r_lane u_red_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (lane_ctl),
		.sample (red_sample),
		.res    (red_res)
	);

	// ------------------------------------------------------------------
	// Merge: N = red_pp * ir_sum, D = red_sum * ir_pp, captured while the
	// lanes clear. Then slope*256*N / D, rounded up, goes to the divider.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (state_q == spo2r_pkg::S_MUL1) begin
			num_s1      <= red_res.pp * ir_res.sum;
			den_s1      <= red_res.sum * ir_res.pp;
			too_long_s1 <= count_q > spo2r_pkg::CNT_W'(spo2r_pkg::WINDOW_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == spo2r_pkg::S_MUL2) begin
			if (too_long_s1)
				err_q <= spo2r_pkg::ST_TOO_LONG;
			else if (den_s1 == '0)
				err_q <= spo2r_pkg::ST_ZERO_DEN;
			else
				err_q <= spo2r_pkg::ST_OK;
		end
	end

	// the divider's dividend register is the register after the slope multiply
	assign div_start    = state_q == spo2r_pkg::S_MUL2 && !too_long_s1 && den_s1 != '0;
	assign div_dividend = {spo2r_pkg::PROD_W'(slope_q) * spo2r_pkg::PROD_W'(num_s1),
		spo2r_pkg::FRAC_W'(0)};

	spo2r_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (den_s1),
		.busy     (div_busy),
		.quotient (div_q),
		.q_ovf    (div_ovf),
		.inexact  (div_inexact)
	);

	// intercept*256 - ceil(quotient), clamped to 0..100 percent
	assign base   = {intercept_q, spo2r_pkg::FRAC_W'(0)};
	assign q_ceil = {1'b0, div_q} + (spo2r_pkg::Q_W + 1)'(div_inexact);
	assign diff_v = base - q_ceil[spo2r_pkg::Q_W-1:0];

	always_comb begin
		if (err_q != spo2r_pkg::ST_OK || div_ovf || q_ceil >= {1'b0, base})
			sat_calc = '0;
		else if (diff_v > spo2r_pkg::Q_W'(spo2r_pkg::FULL_SCALE))
			sat_calc = spo2r_pkg::FULL_SCALE;
		else
			sat_calc = diff_v[spo2r_pkg::SAT_W-1:0];
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= spo2r_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			spo2r_pkg::S_IDLE: begin
				if (in_acc && last_sample) state_d = spo2r_pkg::S_MUL1;
			end
			spo2r_pkg::S_MUL1: begin
				state_d = spo2r_pkg::S_MUL2;
			end
			spo2r_pkg::S_MUL2: begin
				state_d = div_start ? spo2r_pkg::S_DIV : spo2r_pkg::S_FIN;
			end
			spo2r_pkg::S_DIV: begin
				if (!div_busy) state_d = spo2r_pkg::S_FIN;
			end
			spo2r_pkg::S_FIN: begin
				// wait until the output register is free or being emptied
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = spo2r_pkg::S_IDLE;
				end
			end
			default: state_d = spo2r_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	assign out_acc = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)       out_valid_q <= 1'b0;
		else if (load_out) out_valid_q <= 1'b1;
		else if (out_acc)  out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			sat_q    <= sat_calc;
			status_q <= err_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign saturation_value = sat_q;
	assign status           = status_q;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != spo2r_pkg::ST_OK |-> sat_q == '0)
		else $error("error result with nonzero saturation");

	a_full_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> sat_q <= spo2r_pkg::FULL_SCALE)
		else $error("saturation above full scale");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spo2r_pkg::CNT_W'(spo2r_pkg::WINDOW_MAX + 1))
		else $error("pair count past its cap");

	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && last_sample |=> in_stall && state_q == spo2r_pkg::S_MUL1)
		else $error("window end did not start the ratio");

	a_lanes_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == spo2r_pkg::S_MUL1 |=> count_q == '0 && ir_res.sum == '0
			&& red_res.sum == '0)
		else $error("window not cleared after ratio capture");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the SpO2 ratio-of-ratios estimator.
`timescale 1ns / 1ps

module testbench;

	localparam int SETTLE_CYCLES = 70;      // covers the ratio computation through the divider
	localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
	localparam int CYCLE_LIMIT   = 500000;

	typedef enum int {
		W_PULSE,     // DC level plus a pulsatile swing on both channels
		W_NOISE,     // full-range random samples
		W_FLAT_IR,   // constant infrared, so no infrared swing
		W_DARK_RED   // red channel reads zero throughout
	} window_kind_t;

	typedef struct {
		logic [spo2r_pkg::SAT_W-1:0] sat;
		spo2r_pkg::status_t          st;
	} reading_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic [spo2r_pkg::SAMPLE_W-1:0]   ir_sample = '0;
	logic [spo2r_pkg::SAMPLE_W-1:0]   red_sample = '0;
	logic                             last_sample = 1'b0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [spo2r_pkg::SAT_W-1:0]      saturation_value;
	logic [1:0]                       status;
	logic                             cfg_valid = 1'b0;
	logic                             cfg_ready;
	logic [spo2r_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [spo2r_pkg::CAL_W-1:0]      cfg_data = '0;

	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	int hold_left = 0;
	int mismatch_count = 0;
	int cycle_count = 0;

	// Predicted calibration and open-window state
	logic [spo2r_pkg::CAL_W-1:0]    cal_intercept;
	logic [spo2r_pkg::CAL_W-1:0]    cal_slope;
	logic [spo2r_pkg::SUM_W-1:0]    win_ir_sum;
	logic [spo2r_pkg::SUM_W-1:0]    win_red_sum;
	logic [spo2r_pkg::SAMPLE_W-1:0] win_ir_max;
	logic [spo2r_pkg::SAMPLE_W-1:0] win_ir_min;
	logic [spo2r_pkg::SAMPLE_W-1:0] win_red_max;
	logic [spo2r_pkg::SAMPLE_W-1:0] win_red_min;
	logic [spo2r_pkg::CNT_W-1:0]    win_pairs;
	reading_t                       expected_readings[$];
	reading_t                       oldest;

	spo2_ratio_of_ratios_top uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.ir_sample        (ir_sample),
		.red_sample       (red_sample),
		.last_sample      (last_sample),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.saturation_value (saturation_value),
		.status           (status),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, or a forced hold-off while hold_left runs down
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall = 1'b1;
			hold_left--;
		end else begin
			out_stall = ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// Result checker: every accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_readings.size() == 0) begin
				$error("unexpected result: saturation_value %0d status %0d",
					saturation_value, status);
				mismatch_count++;
			end else begin
				oldest = expected_readings.pop_front();
				if (saturation_value !== oldest.sat) begin
					$error("saturation_value: expected %0d, got %0d",
						oldest.sat, saturation_value);
					mismatch_count++;
				end
				if (status !== oldest.st) begin
					$error("status: expected %0d, got %0d", oldest.st, status);
					mismatch_count++;
				end
			end
		end
	end

	function automatic void restart_window();
		win_ir_sum  = '0;
		win_red_sum = '0;
		win_ir_max  = '0;
		win_ir_min  = '1;
		win_red_max = '0;
		win_red_min = '1;
		win_pairs   = '0;
	endfunction

	// Fold one accepted sample pair into the window; on the closing pair
	// predict the saturation reading and start a new window.
	function automatic void absorb_pair(input logic [spo2r_pkg::SAMPLE_W-1:0] ir,
		input logic [spo2r_pkg::SAMPLE_W-1:0] red, input logic last);
		logic [63:0] ir_pp;
		logic [63:0] red_pp;
		logic [63:0] den;
		logic [63:0] scaled;
		logic [63:0] quo;
		logic [63:0] base;
		reading_t    r;
		// past the window limit samples are dropped, the count saturates
		if (win_pairs < spo2r_pkg::WINDOW_MAX) begin
			win_ir_sum  = win_ir_sum + spo2r_pkg::SUM_W'(ir);
			win_red_sum = win_red_sum + spo2r_pkg::SUM_W'(red);
			if (ir > win_ir_max) win_ir_max = ir;
			if (ir < win_ir_min) win_ir_min = ir;
			if (red > win_red_max) win_red_max = red;
			if (red < win_red_min) win_red_min = red;
		end
		if (win_pairs <= spo2r_pkg::WINDOW_MAX)
			win_pairs++;
		if (!last)
			return;
		r.sat = '0;
		r.st  = spo2r_pkg::ST_OK;
		if (win_pairs > spo2r_pkg::WINDOW_MAX) begin
			r.st = spo2r_pkg::ST_TOO_LONG;
		end else begin
			ir_pp  = 64'(win_ir_max - win_ir_min);
			red_pp = 64'(win_red_max - win_red_min);
			den    = 64'(win_red_sum) * ir_pp;
			if (den == 0) begin
				r.st = spo2r_pkg::ST_ZERO_DEN;
			end else begin
				// intercept - slope*R in 1/256 percent, rounded down
				scaled = (64'(cal_slope) << spo2r_pkg::FRAC_W) * red_pp
					* 64'(win_ir_sum);
				quo    = scaled / den;
				if (scaled % den != 0)
					quo++;
				base = 64'(cal_intercept) << spo2r_pkg::FRAC_W;
				if (quo < base)
					r.sat = (base - quo > 64'(spo2r_pkg::FULL_SCALE))
						? spo2r_pkg::FULL_SCALE : spo2r_pkg::SAT_W'(base - quo);
			end
		end
		expected_readings.push_back(r);
		restart_window();
	endfunction

	// One sample request; the payload toggles at random while valid is low.
	task automatic send_pair(input logic [spo2r_pkg::SAMPLE_W-1:0] ir,
		input logic [spo2r_pkg::SAMPLE_W-1:0] red, input logic last);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) begin
				ir_sample   = spo2r_pkg::SAMPLE_W'($urandom);
				red_sample  = spo2r_pkg::SAMPLE_W'($urandom);
				last_sample = 1'($urandom);
				@(negedge clk);
			end
		end
		in_valid    = 1'b1;
		ir_sample   = ir;
		red_sample  = red;
		last_sample = last;
		do @(posedge clk); while (in_stall);
		absorb_pair(ir, red, last);
	endtask

	task automatic send_window(input int len, input window_kind_t kind);
		int ir_dc;
		int ir_amp;
		int red_dc;
		int red_amp;
		int ir_v;
		int red_v;
		ir_dc   = $urandom_range(0, 60000);
		ir_amp  = $urandom_range(1, 5000);
		red_dc  = $urandom_range(0, 60000);
		red_amp = $urandom_range(1, 5000);
		for (int i = 0; i < len; i++) begin
			case (kind)
				W_PULSE: begin
					ir_v  = ir_dc + $urandom_range(0, ir_amp);
					red_v = red_dc + $urandom_range(0, red_amp);
				end
				W_FLAT_IR: begin
					ir_v  = ir_dc;
					red_v = $urandom_range(0, 65535);
				end
				W_DARK_RED: begin
					ir_v  = $urandom_range(0, 65535);
					red_v = 0;
				end
				default: begin
					ir_v  = $urandom_range(0, 65535);
					red_v = $urandom_range(0, 65535);
				end
			endcase
			if (ir_v > 65535) ir_v = 65535;
			if (red_v > 65535) red_v = 65535;
			send_pair(spo2r_pkg::SAMPLE_W'(ir_v), spo2r_pkg::SAMPLE_W'(red_v),
				i == len - 1);
		end
	endtask

	// Mostly plausible pulse windows, the rest noise and degenerate windows
	task automatic send_random_window(output int len);
		int pick;
		window_kind_t kind;
		pick = $urandom_range(99);
		if (pick < 70) begin
			kind = W_PULSE;
			len  = $urandom_range(2, 48);
		end else if (pick < 82) begin
			kind = W_NOISE;
			len  = $urandom_range(1, 16);
		end else if (pick < 89) begin
			kind = W_FLAT_IR;
			len  = $urandom_range(1, 24);
		end else if (pick < 95) begin
			kind = W_DARK_RED;
			len  = $urandom_range(1, 24);
		end else begin
			kind = W_PULSE;
			len  = 1;
		end
		send_window(len, kind);
	endtask

	// Drain all pending readings so the block is idle for register writes.
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register write request; entered at a falling edge.
	task automatic write_cal(input logic [spo2r_pkg::CFG_IDX_W-1:0] idx,
		input logic [spo2r_pkg::CAL_W-1:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == spo2r_pkg::REG_INTERCEPT)
			cal_intercept = val;
		else if (idx == spo2r_pkg::REG_SLOPE)
			cal_slope = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic reconfigure(input logic [spo2r_pkg::CAL_W-1:0] icpt,
		input logic [spo2r_pkg::CAL_W-1:0] slp);
		settle();
		write_cal(spo2r_pkg::REG_INTERCEPT, icpt);
		write_cal(spo2r_pkg::REG_SLOPE, slp);
	endtask

	// Hand-picked windows: one-pair window, full-scale swings, flat and
	// dark channels, both clamps and alternating bit patterns.
	task automatic test_directed_windows();
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		send_pair(16'h1234, 16'd100, 1'b0);
		send_pair(16'h1234, 16'd9000, 1'b0);
		send_pair(16'h1234, 16'd500, 1'b1);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'h0000, 1'b0);
		send_pair(16'h8000, 16'h0000, 1'b1);
		// tiny red swing: reading above 100 percent, clamped
		send_pair(16'h0000, 16'd1000, 1'b0);
		send_pair(16'hFFFF, 16'd1001, 1'b1);
		// huge red swing: reading below zero, clamped
		send_pair(16'd1000, 16'h0000, 1'b0);
		send_pair(16'd1001, 16'hFFFF, 1'b1);
		send_pair(16'hAAAA, 16'h5555, 1'b0);
		send_pair(16'h5555, 16'hAAAA, 1'b1);
	endtask

	task automatic test_calibration_extremes();
		reconfigure(8'd0, 8'd0);
		send_pair(16'h0000, 16'h0000, 1'b0);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		reconfigure(8'd255, 8'd0);
		send_pair(16'd10, 16'd20, 1'b0);
		send_pair(16'd30, 16'd25, 1'b1);
		reconfigure(8'd255, 8'd255);
		send_pair(16'd100, 16'd200, 1'b0);
		send_pair(16'd300, 16'd250, 1'b0);
		send_pair(16'd200, 16'd220, 1'b1);
		reconfigure(8'd0, 8'd255);
		send_window(6, W_PULSE);
		// writes to unmapped indexes must leave the calibration alone
		settle();
		write_cal(spo2r_pkg::CFG_IDX_W'($urandom_range(2, 254)),
			spo2r_pkg::CAL_W'($urandom));
		write_cal(8'hFF, 8'hFF);
		send_window(5, W_PULSE);
		reconfigure(spo2r_pkg::INTERCEPT_RST, spo2r_pkg::SLOPE_RST);
		send_window(4, W_PULSE);
	endtask

	// A window beyond the length limit, long enough for the count to hit
	// its cap, then a short one to show the accumulators came back clean.
	task automatic test_window_limit();
		int saved_pct;
		saved_pct = sender_idle_pct;
		sender_idle_pct = 0;
		send_window(spo2r_pkg::WINDOW_MAX + 2, W_NOISE);
		send_window(3, W_PULSE);
		sender_idle_pct = saved_pct;
	endtask

	// Receiver holds off while short windows keep coming, so the block
	// backs up and stalls its sample input.
	task automatic test_backpressure();
		settle();
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		repeat (10)
			send_window($urandom_range(2, 4), W_PULSE);
	endtask

	task automatic test_random_phase(input int snd_pct, input int rcv_pct, input int items);
		int sent;
		int len;
		sender_idle_pct   = snd_pct;
		receiver_idle_pct = rcv_pct;
		for (int half = 0; half < 2; half++) begin
			if ($urandom_range(3) == 0)
				reconfigure(spo2r_pkg::CAL_W'($urandom), spo2r_pkg::CAL_W'($urandom));
			else
				reconfigure(spo2r_pkg::CAL_W'($urandom_range(85, 130)),
					spo2r_pkg::CAL_W'($urandom_range(10, 45)));
			if ($urandom_range(2) == 0)
				write_cal(spo2r_pkg::CFG_IDX_W'($urandom_range(2, 255)),
					spo2r_pkg::CAL_W'($urandom));
			sent = 0;
			while (sent < items / 2) begin
				send_random_window(len);
				sent += len;
			end
		end
	endtask

	initial begin
		restart_window();
		cal_intercept = spo2r_pkg::INTERCEPT_RST;
		cal_slope     = spo2r_pkg::SLOPE_RST;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		sender_idle_pct   = 29;
		receiver_idle_pct = 52;
		test_directed_windows();
		test_calibration_extremes();
		test_window_limit();
		test_backpressure();
		test_random_phase(29, 52, 200);
		test_random_phase(52, 29, 200);
		test_random_phase(0, 0, 200);

		@(negedge clk);
		in_valid = 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
